// ===== rtl/chbd_pkg.sv =====
// ----------------------------------------------------------------------------
// chbd_pkg: shared types and constants for the complex halfband decimator
// Sample, coefficient and pair word types, register map and datapath widths.
// ----------------------------------------------------------------------------
package chbd_pkg;

    // Datapath widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int PAIR_SUM_W = SAMPLE_W + 1;
    localparam int PROD_W     = PAIR_SUM_W + COEF_W;
    localparam int ACC_W      = 40;
    localparam int CENTER_SH  = 16;
    localparam int ROUND_SH   = 17;
    localparam int RES_W      = ACC_W - ROUND_SH;

    // Register map: coef_0 .. coef_7 at byte address 4*i
    localparam int NUM_COEFS  = 8;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_LO = 2;

    // Queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;
    localparam int FIFO_CNT_W = 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    // One even/odd sample pair, ready for the filter engine
    typedef struct packed {
        sample_t even_i;
        sample_t even_q;
        sample_t odd_i;
        sample_t odd_q;
    } pair_t;

endpackage

// ===== rtl/chbd_front.sv =====
// ----------------------------------------------------------------------------
// chbd_front: input word pairing
// Holds each even sample and pushes it with the following odd sample as one
// pair into the queue toward the filter engine.
// ----------------------------------------------------------------------------
module chbd_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,   // [15:0] sample_i, [31:16] sample_q
    output logic               push,
    output chbd_pkg::pair_t    push_data,
    input  logic               full
);

    logic             holding_reg;
    chbd_pkg::sample_t held_i_reg;
    chbd_pkg::sample_t held_q_reg;
    logic             accept;

    // An even word is always taken; an odd word needs room in the queue
    assign s_axis_tready = !holding_reg || !full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = accept && holding_reg;

    assign push_data.even_i = held_i_reg;
    assign push_data.even_q = held_q_reg;
    assign push_data.odd_i  = s_axis_tdata[15:0];
    assign push_data.odd_q  = s_axis_tdata[31:16];

    // Even/odd phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_reg <= 1'b0;
        end
        else if (accept)
        begin
            holding_reg <= !holding_reg;
        end
    end

    // Held even sample
    always_ff @(posedge clk)
    begin
        if (accept && !holding_reg)
        begin
            held_i_reg <= s_axis_tdata[15:0];
            held_q_reg <= s_axis_tdata[31:16];
        end
    end

endmodule

// ===== rtl/chbd_fifo.sv =====
// ----------------------------------------------------------------------------
// chbd_fifo: short pair queue
// Two-entry queue that decouples word pairing from the filter engine.
// ----------------------------------------------------------------------------
module chbd_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  chbd_pkg::pair_t push_data,
    output logic            full,
    input  logic            pop,
    output chbd_pkg::pair_t pop_data,
    output logic            empty
);

    chbd_pkg::pair_t                   mem_reg [chbd_pkg::FIFO_DEPTH];
    logic [chbd_pkg::FIFO_AW-1:0]      wr_ptr_reg;
    logic [chbd_pkg::FIFO_AW-1:0]      rd_ptr_reg;
    logic [chbd_pkg::FIFO_CNT_W-1:0]   count_reg;

    assign full     = (count_reg == chbd_pkg::FIFO_CNT_W'(chbd_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/chbd_back.sv =====
// ----------------------------------------------------------------------------
// chbd_back: delay lines and filter engine
// Shifts each pair into the even and odd delay lines, runs the symmetric FIR
// one coefficient a cycle on a shared multiplier per component, then rounds,
// saturates and holds the result in the output register.
// ----------------------------------------------------------------------------
module chbd_back
#(
    parameter int TAP_COUNT = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    output logic             pop,
    input  chbd_pkg::pair_t  pop_data,
    input  chbd_pkg::coef_t  coefs [chbd_pkg::NUM_COEFS],
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [15:0] out_i, [31:16] out_q
    output logic             m_axis_tuser    // [0] saturated
);

    localparam int HALF  = TAP_COUNT / 2;
    localparam int BASE  = TAP_COUNT % 2;
    localparam int WLEN  = TAP_COUNT - BASE;
    localparam int MID   = WLEN / 2;
    localparam int CNT_W = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int SW    = chbd_pkg::SAMPLE_W;
    localparam int AW    = chbd_pkg::ACC_W;
    localparam int PSW   = chbd_pkg::PAIR_SUM_W;
    localparam int RW    = chbd_pkg::RES_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_RND  = 3'd4;

    logic [2:0]              state_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    prod_vld_reg;

    chbd_pkg::sample_t       ev_i_reg [TAP_COUNT];
    chbd_pkg::sample_t       ev_q_reg [TAP_COUNT];
    chbd_pkg::sample_t       od_i_reg [TAP_COUNT];
    chbd_pkg::sample_t       od_q_reg [TAP_COUNT];

    chbd_pkg::sample_t       w_i_reg [WLEN];
    chbd_pkg::sample_t       w_q_reg [WLEN];
    chbd_pkg::coef_t         c_reg   [HALF];

    logic signed [chbd_pkg::PROD_W-1:0] prod_i_reg;
    logic signed [chbd_pkg::PROD_W-1:0] prod_q_reg;
    chbd_pkg::acc_t          acc_i_reg;
    chbd_pkg::acc_t          acc_q_reg;

    logic                    out_valid_reg;
    chbd_pkg::sample_t       out_i_reg;
    chbd_pkg::sample_t       out_q_reg;
    logic                    out_sat_reg;

    chbd_pkg::sample_t       center_i;
    chbd_pkg::sample_t       center_q;
    logic signed [PSW-1:0]   pair_i;
    logic signed [PSW-1:0]   pair_q;
    chbd_pkg::acc_t          sum_i;
    chbd_pkg::acc_t          sum_q;
    logic signed [RW-1:0]    res_i;
    logic signed [RW-1:0]    res_q;
    chbd_pkg::sample_t       sat_i;
    chbd_pkg::sample_t       sat_q;
    logic                    clip_i;
    logic                    clip_q;
    logic                    out_load;

    assign pop      = (state_reg == ST_IDLE) && !empty;
    assign out_load = (state_reg == ST_RND) && (!out_valid_reg || m_axis_tready);

    // Center tap comes from the line that the pair sums do not use
    always_comb
    begin
        if (BASE == 0)
        begin
            center_i = od_i_reg[HALF];
            center_q = od_q_reg[HALF];
        end
        else
        begin
            center_i = ev_i_reg[HALF];
            center_q = ev_q_reg[HALF];
        end
    end

    // Symmetric pair from the two ends of the folded working line
    assign pair_i = PSW'(w_i_reg[0]) + PSW'(w_i_reg[WLEN-1]);
    assign pair_q = PSW'(w_q_reg[0]) + PSW'(w_q_reg[WLEN-1]);

    // Round half up to Q1.15 and clip
    assign sum_i = acc_i_reg + AW'(65536);
    assign sum_q = acc_q_reg + AW'(65536);
    assign res_i = sum_i[AW-1:chbd_pkg::ROUND_SH];
    assign res_q = sum_q[AW-1:chbd_pkg::ROUND_SH];

    always_comb
    begin
        clip_i = 1'b1;
        clip_q = 1'b1;
        if (res_i > RW'(32767))
        begin
            sat_i = 16'sh7FFF;
        end
        else if (res_i < -RW'(32768))
        begin
            sat_i = 16'sh8000;
        end
        else
        begin
            sat_i  = res_i[SW-1:0];
            clip_i = 1'b0;
        end
        if (res_q > RW'(32767))
        begin
            sat_q = 16'sh7FFF;
        end
        else if (res_q < -RW'(32768))
        begin
            sat_q = 16'sh8000;
        end
        else
        begin
            sat_q  = res_q[SW-1:0];
            clip_q = 1'b0;
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!empty)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    cnt_reg      <= '0;
                    prod_vld_reg <= 1'b0;
                    state_reg    <= ST_MUL;
                end
                ST_MUL:
                begin
                    prod_vld_reg <= 1'b1;
                    cnt_reg      <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(HALF - 1))
                    begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    state_reg <= ST_RND;
                end
                ST_RND:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Delay lines, index 0 newest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < TAP_COUNT; n++)
            begin
                ev_i_reg[n] <= '0;
                ev_q_reg[n] <= '0;
                od_i_reg[n] <= '0;
                od_q_reg[n] <= '0;
            end
        end
        else if (pop)
        begin
            for (int n = 1; n < TAP_COUNT; n++)
            begin
                ev_i_reg[n] <= ev_i_reg[n-1];
                ev_q_reg[n] <= ev_q_reg[n-1];
                od_i_reg[n] <= od_i_reg[n-1];
                od_q_reg[n] <= od_q_reg[n-1];
            end
            ev_i_reg[0] <= pop_data.even_i;
            ev_q_reg[0] <= pop_data.even_q;
            od_i_reg[0] <= pop_data.odd_i;
            od_q_reg[0] <= pop_data.odd_q;
        end
    end

    // Folded working line: lower half walks down, upper half walks up,
    // so the ends always hold the next symmetric pair
    for (genvar j = 0; j < WLEN; j++)
    begin : g_work
        always_ff @(posedge clk)
        begin
            if (state_reg == ST_LOAD)
            begin
                if (BASE == 0)
                begin
                    w_i_reg[j] <= ev_i_reg[j];
                    w_q_reg[j] <= ev_q_reg[j];
                end
                else
                begin
                    w_i_reg[j] <= od_i_reg[j + BASE];
                    w_q_reg[j] <= od_q_reg[j + BASE];
                end
            end
            else if (state_reg == ST_MUL)
            begin
                if (j < MID - 1)
                begin
                    w_i_reg[j] <= w_i_reg[(j < MID - 1) ? j + 1 : j];
                    w_q_reg[j] <= w_q_reg[(j < MID - 1) ? j + 1 : j];
                end
                else if (j > MID)
                begin
                    w_i_reg[j] <= w_i_reg[(j > MID) ? j - 1 : j];
                    w_q_reg[j] <= w_q_reg[(j > MID) ? j - 1 : j];
                end
            end
        end
    end

    // Coefficient shift line, head always feeds the multipliers
    for (genvar k = 0; k < HALF; k++)
    begin : g_coef
        always_ff @(posedge clk)
        begin
            if (state_reg == ST_LOAD)
            begin
                c_reg[k] <= coefs[k];
            end
            else if (state_reg == ST_MUL)
            begin
                c_reg[k] <= c_reg[(k < HALF - 1) ? k + 1 : k];
            end
        end
    end

    // Multiply stage and accumulator
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_i_reg <= pair_i * c_reg[0];
            prod_q_reg <= pair_q * c_reg[0];
        end
        if (state_reg == ST_LOAD)
        begin
            acc_i_reg <= {{(AW - SW - chbd_pkg::CENTER_SH){center_i[SW-1]}}, center_i,
                          {chbd_pkg::CENTER_SH{1'b0}}};
            acc_q_reg <= {{(AW - SW - chbd_pkg::CENTER_SH){center_q[SW-1]}}, center_q,
                          {chbd_pkg::CENTER_SH{1'b0}}};
        end
        else if ((state_reg == ST_MUL && prod_vld_reg) || state_reg == ST_ACC)
        begin
            acc_i_reg <= acc_i_reg + AW'(prod_i_reg);
            acc_q_reg <= acc_q_reg + AW'(prod_q_reg);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_i_reg   <= sat_i;
            out_q_reg   <= sat_q;
            out_sat_reg <= clip_i || clip_q;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_q_reg, out_i_reg};
    assign m_axis_tuser  = out_sat_reg;

endmodule

// ===== rtl/complex_halfband_decimator_core.sv =====
// The filter engine takes a new pair only once it has finished the last one and
//   its result has entered the output register; the single multiplier per
//   component, one coefficient a cycle, sets the pace of the filter engine.
// Reset: asynchronous, active low; clears coefficients, delay lines, the
//   even/odd phase, the pair queue and the output valid.
// ----------------------------------------------------------------------------
// complex_halfband_decimator_core: complex halfband decimate-by-2 filter
// Pairs even/odd IQ samples, queues the pairs and runs a symmetric FIR on
// them, with rounding and saturation to Q1.15. Coefficients sit on APB.
// ----------------------------------------------------------------------------
module complex_halfband_decimator_core
#(
    parameter int TAP_COUNT = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] sample_i, [31:16] sample_q
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] out_i, [31:16] out_q
    output logic        m_axis_tuser,   // [0] saturated
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [chbd_pkg::PADDR_W-1:0] paddr,
    input  logic [chbd_pkg::PDATA_W-1:0] pwdata,
    output logic [chbd_pkg::PDATA_W-1:0] prdata,
    output logic        pready
);

    localparam int CIW = chbd_pkg::PADDR_W - chbd_pkg::REG_IDX_LO;
    localparam int PW  = chbd_pkg::PDATA_W;
    localparam int CW  = chbd_pkg::COEF_W;

    chbd_pkg::coef_t   coef_reg [chbd_pkg::NUM_COEFS];
    logic [CIW-1:0]    reg_idx;
    logic              cfg_wr;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    chbd_pkg::pair_t   push_data;
    chbd_pkg::pair_t   pop_data;

    // Register access
    assign pready  = 1'b1;
    assign reg_idx = paddr[chbd_pkg::PADDR_W-1:chbd_pkg::REG_IDX_LO];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = {{(PW - CW){coef_reg[reg_idx][CW-1]}}, coef_reg[reg_idx]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < chbd_pkg::NUM_COEFS; r++)
            begin
                coef_reg[r] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            coef_reg[reg_idx] <= pwdata[CW-1:0];
        end
    end

    // Word pairing
    chbd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push          (push),
        .push_data     (push_data),
        .full          (full)
    );

    // Pair queue
    chbd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // Filter engine
    chbd_back
    #(
        .TAP_COUNT (TAP_COUNT)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .pop           (pop),
        .pop_data      (pop_data),
        .coefs         (coef_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
